[sv/swfd_pkg.sv]
package swfd_pkg;

    // reply layout
    localparam int BYTES_PER_WORD  = 2;
    localparam int FRAME_BYTES     = 9;
    localparam int WORD_BYTES      = BYTES_PER_WORD + 1;
    localparam int WORDS_RAW       = FRAME_BYTES / WORD_BYTES;
    localparam int WORDS_PER_FRAME = (WORDS_RAW < 1) ? 1 : WORDS_RAW;

    localparam int OFFSET_W = $clog2(WORD_BYTES);
    localparam int WORD_W   = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;

    typedef logic [OFFSET_W-1:0] offset_cnt_t;
    typedef logic [WORD_W-1:0]   word_cnt_t;

    // word kinds
    localparam int WORD_CO2  = 0;
    localparam int WORD_TEMP = 1;
    localparam int WORD_HUM  = 2;

    // fixed-point scaling
    localparam int          GAIN_W      = 15;
    localparam int          PROD_W      = 16 + GAIN_W;
    localparam int          SCALED_W    = 17;
    localparam logic [14:0] TEMP_GAIN   = 15'd17500;
    localparam logic [14:0] HUM_GAIN    = 15'd10000;
    localparam logic [16:0] TEMP_OFFSET = 17'd4500;

    // configuration
    localparam int          CFG_INDEX_W    = 1;
    localparam logic [0:0]  CFG_POLYNOMIAL = 1'b0;
    localparam logic [0:0]  CFG_INITIAL    = 1'b1;
    localparam logic [7:0]  POLY_RESET     = 8'h31;
    localparam logic [7:0]  INIT_RESET     = 8'hFF;

    // result beat layout
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic       emit;
        word_cnt_t  word;
        logic [1:0] word_index;
        logic [15:0] raw_word;
        logic       crc_ok;
        logic       frame_ok;
        logic       last;
    } trk_result_t;

    // msb-first crc-8 over one byte
    function automatic logic [7:0] crc8_byte(logic [7:0] crc_in, logic [7:0] data,
                                             logic [7:0] poly);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

endpackage

[sv/swfd_word_track.sv]
module swfd_word_track (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic [7:0]            rx_byte,
    input  logic                  frame_start,
    input  logic [7:0]            crc_polynomial,
    input  logic [7:0]            crc_initial,
    output swfd_pkg::trk_result_t result
);

    swfd_pkg::offset_cnt_t offset_reg, offset_next, offset_eff;
    swfd_pkg::word_cnt_t   word_reg, word_next, word_eff;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] high_reg, high_next;
    logic [7:0] low_reg, low_next;
    logic       all_good_reg, all_good_next, all_good_eff;
    logic       is_crc_byte, is_last, ok;

    always_comb begin
        offset_eff   = frame_start ? '0 : offset_reg;
        word_eff     = frame_start ? '0 : word_reg;
        all_good_eff = frame_start ? 1'b1 : all_good_reg;

        is_crc_byte = (offset_eff == swfd_pkg::OFFSET_W'(swfd_pkg::BYTES_PER_WORD));
        is_last     = (word_eff == swfd_pkg::WORD_W'(swfd_pkg::WORDS_PER_FRAME - 1));
        ok          = (rx_byte == crc_reg);

        offset_next   = offset_reg;
        word_next     = word_reg;
        crc_next      = crc_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        all_good_next = all_good_reg;

        if (is_crc_byte) begin
            offset_next = '0;
            if (is_last) begin
                word_next     = '0;
                all_good_next = 1'b1;
            end else begin
                word_next     = word_eff + 1'b1;
                all_good_next = all_good_eff & ok;
            end
        end else begin
            offset_next   = offset_eff + 1'b1;
            word_next     = word_eff;
            all_good_next = all_good_eff;
            low_next      = rx_byte;
            if (offset_eff == '0) begin
                crc_next  = swfd_pkg::crc8_byte(crc_initial, rx_byte, crc_polynomial);
                high_next = 8'h00;
            end else begin
                crc_next  = swfd_pkg::crc8_byte(crc_reg, rx_byte, crc_polynomial);
                high_next = low_reg;
            end
        end
    end

    always_comb begin
        result.emit       = is_crc_byte;
        result.word       = word_eff;
        result.word_index = 2'(word_eff);
        result.raw_word   = {high_reg, low_reg};
        result.crc_ok     = ok;
        result.frame_ok   = is_last & all_good_eff & ok;
        result.last       = is_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg   <= '0;
            word_reg     <= '0;
            crc_reg      <= swfd_pkg::INIT_RESET;
            high_reg     <= 8'h00;
            low_reg      <= 8'h00;
            all_good_reg <= 1'b1;
        end else if (step_en) begin
            offset_reg   <= offset_next;
            word_reg     <= word_next;
            crc_reg      <= crc_next;
            high_reg     <= high_next;
            low_reg      <= low_next;
            all_good_reg <= all_good_next;
        end
    end

endmodule

[sv/swfd_scale.sv]
module swfd_scale (
    input  swfd_pkg::word_cnt_t                word,
    input  logic [15:0]                        raw_word,
    output logic signed [swfd_pkg::SCALED_W-1:0] scaled_value
);

    logic [swfd_pkg::GAIN_W-1:0] gain;
    logic [swfd_pkg::PROD_W-1:0] prod;
    logic [swfd_pkg::SCALED_W-1:0] quot;
    logic is_temp, is_hum;

    always_comb begin
        is_temp = (32'(word) == 32'(swfd_pkg::WORD_TEMP));
        is_hum  = (32'(word) == 32'(swfd_pkg::WORD_HUM));
        gain    = is_temp ? swfd_pkg::TEMP_GAIN : swfd_pkg::HUM_GAIN;
        prod    = swfd_pkg::PROD_W'(raw_word) * swfd_pkg::PROD_W'(gain);
        // floor of product over 65536
        quot    = swfd_pkg::SCALED_W'(prod[swfd_pkg::PROD_W-1:16]);
        priority if (is_temp) begin
            scaled_value = quot - swfd_pkg::TEMP_OFFSET;
        end else if (is_hum) begin
            scaled_value = quot;
        end else begin
            scaled_value = swfd_pkg::SCALED_W'(raw_word);
        end
    end

endmodule

[sv/sensor_word_frame_decoder.sv]
// channel   | handshake                     | payload
// ----------+-------------------------------+------------------------------------------
// input     | s_axis_tvalid / s_axis_tready | tdata: rx_byte; tuser: frame_start
// result    | m_axis_tvalid / m_axis_tready | tdata: raw, scaled, crc_ok, frame_ok;
//           |                               | tuser: word_index; tlast: last
// config    | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// one byte per cycle while the result side keeps up; a crc byte, once taken, passes
// the input register, then crc check and scaling into the result register
// reset is synchronous on aresetn low: polynomial 0x31, initial value 0xff, frame restarts
// data bytes never wait in the input register; a crc byte waits there only while a
// finished result beat sits unaccepted in the result register, and input stalls with it
module sensor_word_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [swfd_pkg::OUT_DATA_W-1:0] m_axis_tdata, // [15:0] raw_word,
                                                       // [32:16] scaled_value,
                                                       // [33] crc_ok, [34] frame_ok,
                                                       // [39:35] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [swfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]  cfg_data
);

    // configuration registers
    logic [7:0] poly_reg;
    logic [7:0] init_reg;

    // input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // result register
    logic        out_vld_reg, out_vld_next;
    logic [1:0]  out_index_reg;
    logic [15:0] out_raw_reg;
    logic signed [swfd_pkg::SCALED_W-1:0] out_scaled_reg;
    logic        out_crc_ok_reg;
    logic        out_frame_ok_reg;
    logic        out_last_reg;

    swfd_pkg::trk_result_t trk;
    logic signed [swfd_pkg::SCALED_W-1:0] scaled;
    logic out_free;
    logic proceed;
    logic step_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= swfd_pkg::POLY_RESET;
            init_reg <= swfd_pkg::INIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                swfd_pkg::CFG_POLYNOMIAL: poly_reg <= cfg_data;
                swfd_pkg::CFG_INITIAL:    init_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // the held byte moves on unless it needs the result register and that is still full
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign proceed       = !in_vld_reg || !trk.emit || out_free;
    assign step_en       = in_vld_reg && proceed;
    assign s_axis_tready = proceed;

    swfd_word_track u_track (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (step_en),
        .rx_byte        (in_byte_reg),
        .frame_start    (in_start_reg),
        .crc_polynomial (poly_reg),
        .crc_initial    (init_reg),
        .result         (trk)
    );

    swfd_scale u_scale (
        .word         (trk.word),
        .raw_word     (trk.raw_word),
        .scaled_value (scaled)
    );

    always_comb begin
        in_vld_next = proceed ? s_axis_tvalid : in_vld_reg;
        out_vld_next = out_vld_reg;
        if (out_free) begin
            out_vld_next = step_en && trk.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (proceed) begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
        if (out_free && step_en && trk.emit) begin
            out_index_reg    <= trk.word_index;
            out_raw_reg      <= trk.raw_word;
            out_scaled_reg   <= scaled;
            out_crc_ok_reg   <= trk.crc_ok;
            out_frame_ok_reg <= trk.frame_ok;
            out_last_reg     <= trk.last;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'b0, out_frame_ok_reg, out_crc_ok_reg, out_scaled_reg,
                            out_raw_reg};
    assign m_axis_tuser  = out_index_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[tb/tb_sensor_word_frame_decoder.sv]
`timescale 1ns / 100ps

module tb_sensor_word_frame_decoder;

    localparam int STALL_LIMIT = 1000;   // cycles with no beat on any channel
    localparam int PHASE_BYTES = 240;    // random bytes per configuration setting
    localparam int NUM_PHASES  = 8;

    // one decoded word as it leaves the block
    typedef struct packed {
        logic [1:0]  word_index;
        logic [15:0] raw_word;
        logic [16:0] scaled_value;
        logic        crc_ok;
        logic        frame_ok;
        logic        last;
    } word_beat_t;

    // tracks the reply decoder and holds the words it still owes
    class word_result_board;
        logic [7:0]  crc_poly  = 8'h31;
        logic [7:0]  crc_init  = 8'hFF;
        logic [3:0]  byte_pos  = 4'd0;
        logic [7:0]  crc_run   = 8'hFF;
        logic [7:0]  data_hi   = 8'h00;
        logic [7:0]  data_lo   = 8'h00;
        logic        all_good  = 1'b1;
        word_beat_t  expected_words[$];
        int          errors        = 0;
        int          words_checked = 0;
        int          bad_crc_words = 0;
        int          good_frames   = 0;

        function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
            logic [7:0] c;
            c = crc ^ data;
            for (int k = 0; k < 8; k++)
                c = c[7] ? ((c << 1) ^ crc_poly) : (c << 1);
            return c;
        endfunction

        // correct check byte for a two-byte word under the current setting
        function logic [7:0] crc_word(logic [7:0] hi, logic [7:0] lo);
            return crc8_step(crc8_step(crc_init, hi), lo);
        endfunction

        function void set_reg(logic [swfd_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] val);
            if (idx == swfd_pkg::CFG_POLYNOMIAL)
                crc_poly = val;
            else if (idx == swfd_pkg::CFG_INITIAL)
                crc_init = val;
        endfunction

        function void decode_byte(logic [7:0] b, logic start);
            word_beat_t  w;
            logic [3:0]  word;
            logic [3:0]  offset;
            logic [15:0] raw;
            logic [31:0] prod;
            logic        ok;
            logic        is_last;
            if (start) begin
                byte_pos = 4'd0;
                all_good = 1'b1;
            end
            if (byte_pos >= swfd_pkg::WORD_BYTES * swfd_pkg::WORDS_PER_FRAME)
                byte_pos = 4'd0;
            word   = 4'(byte_pos / swfd_pkg::WORD_BYTES);
            offset = 4'(byte_pos % swfd_pkg::WORD_BYTES);
            if (offset < swfd_pkg::BYTES_PER_WORD) begin
                if (offset == 0) begin
                    crc_run = crc8_step(crc_init, b);
                    data_hi = 8'h00;
                end else begin
                    crc_run = crc8_step(crc_run, b);
                    data_hi = data_lo;
                end
                data_lo  = b;
                byte_pos = byte_pos + 4'd1;
                return;
            end
            raw      = {data_hi, data_lo};
            ok       = (b == crc_run);
            all_good = all_good & ok;
            is_last  = (word + 1 >= swfd_pkg::WORDS_PER_FRAME);
            case (word)
                swfd_pkg::WORD_TEMP: begin
                    prod = 32'd17500 * {16'd0, raw};
                    w.scaled_value = prod[32-1:16] - 17'd4500;
                end
                swfd_pkg::WORD_HUM: begin
                    prod = 32'd10000 * {16'd0, raw};
                    w.scaled_value = {1'b0, prod[31:16]};
                end
                default: w.scaled_value = {1'b0, raw};
            endcase
            w.word_index = word[1:0];
            w.raw_word   = raw;
            w.crc_ok     = ok;
            w.frame_ok   = is_last ? all_good : 1'b0;
            w.last       = is_last;
            expected_words.push_back(w);
            if (is_last) begin
                byte_pos = 4'd0;
                all_good = 1'b1;
            end else begin
                byte_pos = byte_pos + 4'd1;
            end
        endfunction

        function void cmp(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            end
        endfunction

        function void check_word(logic [swfd_pkg::OUT_DATA_W-1:0] data, logic [1:0] user,
                                 logic lst);
            word_beat_t w;
            if (expected_words.size() == 0) begin
                errors++;
                $error("result beat with no word pending: raw 0x%0h", data[15:0]);
                return;
            end
            w = expected_words.pop_front();
            words_checked++;
            if (!w.crc_ok)
                bad_crc_words++;
            if (w.last && w.frame_ok)
                good_frames++;
            cmp("word_index", w.word_index, user);
            cmp("raw_word", w.raw_word, data[15:0]);
            cmp("scaled_value", w.scaled_value, data[32:16]);
            cmp("crc_ok", w.crc_ok, data[33]);
            cmp("frame_ok", w.frame_ok, data[34]);
            cmp("last", w.last, lst);
            cmp("pad", 32'd0, data[swfd_pkg::OUT_DATA_W-1:35]);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic                  s_axis_tuser  = 1'b0;    // [0] frame_start
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [swfd_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // [15:0] raw, [32:16] scaled,
                                                    // [33] crc_ok, [34] frame_ok
    logic [1:0]            m_axis_tuser;            // [1:0] word_index
    logic                  m_axis_tlast;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [swfd_pkg::CFG_INDEX_W-1:0] cfg_index = swfd_pkg::CFG_POLYNOMIAL;
    logic [7:0]            cfg_data      = 8'h00;

    word_result_board sb = new();

    // sender and receiver pacing, steered from the main sequence
    bit tx_calm    = 1'b0;   // no gaps between input beats
    bit rx_calm    = 1'b0;   // result side always ready
    int rx_hold    = 0;      // one long receiver hold-off, in cycles
    int bytes_sent = 0;

    sensor_word_frame_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // beat monitor: results are checked before the same edge's input is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.decode_byte(s_axis_tdata, s_axis_tuser);
        end
    end

    // watchdog on cycles with no beat anywhere
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready) || !aresetn)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat for %0d cycles, %0d words still owed",
                 STALL_LIMIT, sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls, calm stretches and one long hold-off
    initial begin
        int w;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold) @(posedge aclk);
                rx_hold = 0;
            end else begin
                w = rx_calm ? 0 : $urandom_range(0, 7);
                if (w > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (w) @(posedge aclk);
                end
                m_axis_tready <= 1'b1;
                do
                    @(posedge aclk);
                while (!(m_axis_tvalid && m_axis_tready) && rx_hold == 0);
            end
        end
    end

    // one input beat; tvalid stays high across back-to-back beats
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        do
            @(posedge aclk);
        while (!(s_axis_tvalid && s_axis_tready));
        bytes_sent++;
    endtask

    // reply of three words (co2 in the low 16 bits), bad marks words with a wrong
    // check byte, nbytes cuts the reply short
    task automatic send_frame(input logic [47:0] words, input logic [2:0] bad,
                              input logic start, input int nbytes);
        logic [7:0] seq[9];
        logic [7:0] hi;
        logic [7:0] lo;
        for (int k = 0; k < 3; k++) begin
            hi = words[k*16+8 +: 8];
            lo = words[k*16 +: 8];
            seq[3*k]   = hi;
            seq[3*k+1] = lo;
            seq[3*k+2] = sb.crc_word(hi, lo) ^ (bad[k] ? 8'($urandom_range(1, 255)) : 8'h00);
        end
        for (int k = 0; k < nbytes && k < 9; k++)
            send_byte(seq[k], (k == 0) ? start : 1'b0);
    endtask

    // stop sending and wait for every owed word
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic write_config(input logic [7:0] poly, input logic [7:0] init_val);
        cfg_valid <= 1'b1;
        cfg_index <= swfd_pkg::CFG_POLYNOMIAL;
        cfg_data  <= poly;
        do
            @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        sb.set_reg(swfd_pkg::CFG_POLYNOMIAL, poly);
        cfg_index <= swfd_pkg::CFG_INITIAL;
        cfg_data  <= init_val;
        do
            @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        sb.set_reg(swfd_pkg::CFG_INITIAL, init_val);
        cfg_valid <= 1'b0;
    endtask

    // mostly random words, with the range ends now and then
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [7:0] poly_set[NUM_PHASES];
        logic [7:0] init_set[NUM_PHASES];
        int         phase_start;
        int         kind;
        bit         paused;
        poly_set = '{8'h00, 8'hFF, 8'h31, 8'h07, 8'h00, 8'h80, 8'hFF, 8'h31};
        init_set = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'hFF};
        poly_set[4] = 8'($urandom);
        init_set[6] = 8'($urandom);
        paused = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset setting: all-zero reply, cut-off reply, resync with
        // a bad temperature check byte at full scale, then a word with no start mark
        send_frame(48'h0, 3'b000, 1'b1, 9);
        send_frame({16'hFFFF, 16'hFFFF, 16'hFFFF}, 3'b000, 1'b1, 4);
        send_frame({16'hFFFF, 16'hFFFF, 16'hFFFF}, 3'b010, 1'b1, 9);
        send_frame({16'h0000, 16'h8000, 16'h01F4}, 3'b000, 1'b0, 3);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // registers change only with the block idle
            drain();
            repeat (4) @(posedge aclk);
            write_config(poly_set[phase], init_set[phase]);
            rx_calm = (phase == 3);
            if (phase == 2)
                rx_hold = 150;   // result side blocks while replies keep coming
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                kind = $urandom_range(0, 99);
                if (kind < 80) begin
                    // well-formed reply, sometimes relying on the frame wrap
                    send_frame({pick_word(), pick_word(), pick_word()},
                               {$urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
                                $urandom_range(0, 4) == 0},
                               $urandom_range(0, 9) < 7, 9);
                end else if (kind < 92) begin
                    send_frame({pick_word(), pick_word(), pick_word()}, 3'b000, 1'b1,
                               $urandom_range(1, 8));
                end else begin
                    // line noise with stray start marks
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                end
                if (phase == 5 && !paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (8) @(posedge aclk);

        $display("sent %0d bytes over %0d crc settings; checked %0d words",
                 bytes_sent, NUM_PHASES + 1, sb.words_checked);
        $display("%0d words with a bad check byte, %0d replies fully good",
                 sb.bad_crc_words, sb.good_frames);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
sv/swfd_pkg.sv
sv/swfd_word_track.sv
sv/swfd_scale.sv
sv/sensor_word_frame_decoder.sv
tb/tb_sensor_word_frame_decoder.sv
